// ===== design/rop_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rop_pkg
// Shared types and codes of the integer reduction operator ALU.
// ---------------------------------------------------------------------------
package rop_pkg;

    localparam int unsigned ValW = 64;
    localparam int unsigned LocW = 32;
    localparam int unsigned HalfW = ValW / 2;
    localparam int unsigned CfgIdxW = 4;
    localparam int unsigned CfgDataW = 4;
    localparam int unsigned WidthW = 7;

    typedef enum logic [3:0] {
        OP_SUM    = 4'd0,
        OP_PROD   = 4'd1,
        OP_BAND   = 4'd2,
        OP_BOR    = 4'd3,
        OP_BXOR   = 4'd4,
        OP_LAND   = 4'd5,
        OP_LOR    = 4'd6,
        OP_LXOR   = 4'd7,
        OP_MAX    = 4'd8,
        OP_MIN    = 4'd9,
        OP_MAXLOC = 4'd10,
        OP_MINLOC = 4'd11
    } t_op;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_OPERATION = 4'd0,
        CFG_FORMAT    = 4'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FMT_W8  = 2'd0,
        FMT_W16 = 2'd1,
        FMT_W32 = 2'd2,
        FMT_W64 = 2'd3
    } t_fmt_width;

    typedef struct packed {
        logic [3:0] op;
        logic       fmt_signed;
        logic [1:0] fmt_width;
    } t_cfg;

    typedef struct packed {
        logic [ValW-1:0]        incoming_value;
        logic [ValW-1:0]        accum_value;
        logic signed [LocW-1:0] incoming_loc;
        logic signed [LocW-1:0] accum_loc;
        logic                   last;
    } t_item;

    // partial products travel separately so the final add sits after a register
    typedef struct packed {
        logic [ValW-1:0]        value;
        logic signed [LocW-1:0] loc;
        logic                   last;
        logic                   is_prod;
        logic [ValW-1:0]        mask;
        logic [ValW-1:0]        pp_low;
        logic [HalfW-1:0]       pp_cross_a;
        logic [HalfW-1:0]       pp_cross_b;
    } t_mid;

endpackage

// ===== design/rop_cfg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rop_cfg
// Operation and element format registers behind a plain write port.
// ---------------------------------------------------------------------------
module rop_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rop_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [rop_pkg::CfgDataW-1:0]   i_cfg_data,
    output rop_pkg::t_cfg                  o_cfg
);
    import rop_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OPERATION: n_cfg.op = i_cfg_data[3:0];
                CFG_FORMAT: begin
                    n_cfg.fmt_width  = i_cfg_data[1:0];
                    n_cfg.fmt_signed = i_cfg_data[2];
                end
                default: ;  // unknown index: ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/rop_stage.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rop_stage
// Masks the operands, evaluates every operation except the product sum,
// and registers the result together with the product's partial terms.
// ---------------------------------------------------------------------------
module rop_stage #(
    parameter int MAX_WIDTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  rop_pkg::t_cfg  i_cfg,
    input  rop_pkg::t_item i_item,
    output logic           o_valid,
    output rop_pkg::t_mid  o_mid
);
    import rop_pkg::*;

    localparam logic [WidthW-1:0] MaxW = WidthW'(MAX_WIDTH);

    logic [WidthW-1:0]      w_sel;
    logic [WidthW-1:0]      w_eff;
    logic [ValW-1:0]        mask;
    logic [ValW-1:0]        flip;
    logic [ValW-1:0]        a;
    logic [ValW-1:0]        b;
    logic [ValW-1:0]        a_key;
    logic [ValW-1:0]        b_key;
    logic                   lt_ab;
    logic                   lt_ba;
    logic                   eq_ab;
    logic                   a_nz;
    logic                   b_nz;
    logic signed [LocW-1:0] loc_lo;
    logic [ValW-1:0]        res;
    logic signed [LocW-1:0] res_loc;
    t_mid                   n_mid;
    t_mid                   r_mid;
    logic                   r_valid;

    always_comb begin
        case (i_cfg.fmt_width)
            FMT_W8:  w_sel = WidthW'(8);
            FMT_W16: w_sel = WidthW'(16);
            FMT_W32: w_sel = WidthW'(32);
            FMT_W64: w_sel = WidthW'(64);
            default: w_sel = WidthW'(64);
        endcase
    end

    assign w_eff = (w_sel > MaxW) ? MaxW : w_sel;
    assign mask  = {ValW{1'b1}} >> (WidthW'(ValW) - w_eff);
    // biasing the sign bit turns a signed compare into an unsigned one
    assign flip  = i_cfg.fmt_signed ? (ValW'(1) << (w_eff - WidthW'(1))) : '0;

    assign a     = i_item.accum_value & mask;
    assign b     = i_item.incoming_value & mask;
    assign a_key = a ^ flip;
    assign b_key = b ^ flip;
    assign lt_ab = a_key < b_key;
    assign lt_ba = b_key < a_key;
    assign eq_ab = a == b;
    assign a_nz  = |a;
    assign b_nz  = |b;
    assign loc_lo = (i_item.incoming_loc < i_item.accum_loc) ?
                    i_item.incoming_loc : i_item.accum_loc;

    always_comb begin
        res     = a;
        res_loc = i_item.accum_loc;
        case (i_cfg.op)
            OP_SUM:  res = a + b;
            OP_PROD: res = a;
            OP_BAND: res = a & b;
            OP_BOR:  res = a | b;
            OP_BXOR: res = a ^ b;
            OP_LAND: res = ValW'(a_nz & b_nz);
            OP_LOR:  res = ValW'(a_nz | b_nz);
            OP_LXOR: res = ValW'(a_nz ^ b_nz);
            OP_MAX:  res = lt_ab ? b : a;
            OP_MIN:  res = lt_ba ? b : a;
            OP_MAXLOC: begin
                if (lt_ab) begin
                    res     = b;
                    res_loc = i_item.incoming_loc;
                end else if (eq_ab) begin
                    res_loc = loc_lo;
                end
            end
            OP_MINLOC: begin
                if (lt_ba) begin
                    res     = b;
                    res_loc = i_item.incoming_loc;
                end else if (eq_ab) begin
                    res_loc = loc_lo;
                end
            end
            default: ;  // unused codes pass the accumulated element through
        endcase
    end

    always_comb begin
        n_mid.value      = res & mask;
        n_mid.loc        = res_loc;
        n_mid.last       = i_item.last;
        n_mid.is_prod    = i_cfg.op == OP_PROD;
        n_mid.mask       = mask;
        n_mid.pp_low     = a[HalfW-1:0] * b[HalfW-1:0];
        n_mid.pp_cross_a = HalfW'(a[ValW-1:HalfW] * b[HalfW-1:0]);
        n_mid.pp_cross_b = HalfW'(a[HalfW-1:0] * b[ValW-1:HalfW]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid <= n_mid;
        end
    end

    assign o_valid = r_valid;
    assign o_mid   = r_mid;

endmodule

// ===== design/integer_reduction_op_alu.sv =====
`timescale 1ns / 1ps
// throughput: one word per cycle while the output is not stalled; three register stages (input, operate, result)
// the stages advance independently, so a bubble closes up under output stall
// reset (synchronous, active low) empties the pipeline and clears both
// configuration registers to sum on 8-bit unsigned elements
// ---------------------------------------------------------------------------
// integer_reduction_op_alu
// Element-wise reduction ALU: combines an incoming and an accumulated
// element with location under the configured operation and format.
// ---------------------------------------------------------------------------
module integer_reduction_op_alu #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rop_pkg::CfgIdxW-1:0]         i_cfg_idx,
    input  logic [rop_pkg::CfgDataW-1:0]        i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [rop_pkg::ValW-1:0]            i_incoming_value,
    input  logic [rop_pkg::ValW-1:0]            i_accum_value,
    input  logic signed [rop_pkg::LocW-1:0]     i_incoming_loc,
    input  logic signed [rop_pkg::LocW-1:0]     i_accum_loc,
    input  logic                                i_last_element,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [rop_pkg::ValW-1:0]            o_result_value,
    output logic signed [rop_pkg::LocW-1:0]     o_result_loc,
    output logic                                o_last_out
);
    import rop_pkg::*;

    t_cfg                   cfg;
    t_item                  r_item;
    logic                   r_in_valid;
    logic                   mid_valid;
    t_mid                   mid;
    logic                   r_out_valid;
    logic [ValW-1:0]        r_value;
    logic signed [LocW-1:0] r_loc;
    logic                   r_last;
    logic [ValW-1:0]        n_value;
    logic [ValW-1:0]        prod;
    logic [HalfW-1:0]       cross_sum;
    logic                   ready_out;
    logic                   ready_mid;
    logic                   ready_in;

    rop_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // a stage takes a new word when it is empty or its word moves on
    assign ready_out = !r_out_valid || !i_stall;
    assign ready_mid = !mid_valid || ready_out;
    assign ready_in  = !r_in_valid || ready_mid;
    assign o_stall   = !ready_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (ready_in) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_in) begin
            r_item.incoming_value <= i_incoming_value;
            r_item.accum_value    <= i_accum_value;
            r_item.incoming_loc   <= i_incoming_loc;
            r_item.accum_loc      <= i_accum_loc;
            r_item.last           <= i_last_element;
        end
    end

    rop_stage #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (ready_mid),
        .i_valid (r_in_valid),
        .i_cfg   (cfg),
        .i_item  (r_item),
        .o_valid (mid_valid),
        .o_mid   (mid)
    );

    // the wrapped 64-bit product: low half of the full 128-bit product
    assign cross_sum = mid.pp_cross_a + mid.pp_cross_b;
    assign prod      = mid.pp_low + {cross_sum, HalfW'(0)};
    assign n_value   = mid.is_prod ? (prod & mid.mask) : mid.value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ready_out) begin
            r_out_valid <= mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_out) begin
            r_value <= n_value;
            r_loc   <= mid.loc;
            r_last  <= mid.last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_value;
    assign o_result_loc   = r_loc;
    assign o_last_out     = r_last;

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !mid_valid && !r_in_valid)
        else $error("pipeline not empty after reset");

    a_mid_to_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_valid && ready_out |=> o_valid)
        else $error("operate stage word lost on its way to the output");

    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !ready_mid |=> r_in_valid && $stable(r_item))
        else $error("input stage word changed while blocked");

    a_in_to_mid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && ready_mid |=> mid_valid)
        else $error("input stage word lost on its way to the operate stage");

endmodule
